### rtl/core/dtok_pkg.sv
// shared types, constants and character classes for the delimiter tokenizer
package dtok_pkg;

  localparam int unsigned DefTokenCapacity = 32;

  localparam logic [7:0] CharQuote = 8'h22;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DELIM
  } dtok_state_e;

  function automatic logic is_delim(input logic [7:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      8'h3A, 8'h2E, 8'h2C, 8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B,
      8'h5D, 8'h3D, 8'h2B, 8'h2D, 8'h3B, 8'h22, 8'h27: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A);
  endfunction

endpackage

### rtl/core/dtok_store.sv
// token character memory, one write port and one registered read port
module dtok_store #(
  parameter int unsigned TokenCapacity = dtok_pkg::DefTokenCapacity,
  parameter int unsigned AddrW = (TokenCapacity > 1) ? $clog2(TokenCapacity) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);
  import dtok_pkg::*;

  logic [7:0] mem [TokenCapacity];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/core/dtok_ctrl.sv
// tokenizer sequencer: collects bytes, drains tokens from the store, output register
module dtok_ctrl #(
  parameter int unsigned TokenCapacity = dtok_pkg::DefTokenCapacity,
  parameter int unsigned AddrW = (TokenCapacity > 1) ? $clog2(TokenCapacity) : 1,
  parameter int unsigned CountW = $clog2(TokenCapacity + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       input_byte_i,
  input  logic             end_of_input_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       token_char_o,
  output logic             token_last_o,
  output logic             is_delimiter_o,
  output logic             in_string_o,
  output logic             truncated_o,
  output logic             wr_en_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic [7:0]       wr_data_o,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [7:0]       rd_data_i
);
  import dtok_pkg::*;

  dtok_state_e       state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic              str_q, str_d;
  logic              ovf_q, ovf_d;
  logic [7:0]        delim_q, delim_d;

  logic              out_valid_q;
  logic [7:0]        out_char_q;
  logic              out_last_q, out_delim_q, out_str_q, out_trunc_q;

  logic              slot_free;
  logic              load;
  logic [7:0]        ld_char;
  logic              ld_last, ld_delim, ld_trunc;
  logic              idx_last;

  assign slot_free = !out_valid_q || out_ready_i;
  assign idx_last  = (CountW'(idx_q) + CountW'(1)) == count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      str_q   <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      str_q   <= str_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delim_q <= delim_d;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    str_d      = str_q;
    ovf_d      = ovf_q;
    delim_d    = delim_q;
    in_ready_o = 1'b0;
    wr_en_o    = 1'b0;
    wr_addr_o  = count_q[AddrW-1:0];
    wr_data_o  = input_byte_i;
    rd_en_o    = 1'b0;
    rd_addr_o  = idx_q;
    load       = 1'b0;
    ld_char    = rd_data_i;
    ld_last    = idx_last;
    ld_delim   = 1'b0;
    ld_trunc   = ovf_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (end_of_input_i) begin
            count_d = '0;
            ovf_d   = 1'b0;
            str_d   = 1'b0;
          end else if (is_delim(input_byte_i)) begin
            delim_d = input_byte_i;
            if (count_q == '0) begin
              state_d = ST_DELIM;
            end else begin
              // fetch the first pending character
              rd_en_o   = 1'b1;
              rd_addr_o = '0;
              idx_d     = '0;
              state_d   = ST_LOAD;
            end
          end else if (!(is_space(input_byte_i) && !str_q)) begin
            if (count_q < CountW'(TokenCapacity)) begin
              wr_en_o = 1'b1;
              count_d = count_q + CountW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
      end
      ST_LOAD: begin
        if (slot_free) begin
          load = 1'b1;
          if (idx_last) begin
            state_d = ST_DELIM;
          end else begin
            // prefetch the next character while this one goes out
            rd_en_o   = 1'b1;
            rd_addr_o = idx_q + AddrW'(1);
            idx_d     = idx_q + AddrW'(1);
          end
        end
      end
      ST_DELIM: begin
        ld_char  = delim_q;
        ld_last  = 1'b1;
        ld_delim = 1'b1;
        ld_trunc = 1'b0;
        if (slot_free) begin
          load    = 1'b1;
          count_d = '0;
          ovf_d   = 1'b0;
          if (delim_q == CharQuote) begin
            str_d = !str_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q  <= ld_char;
      out_last_q  <= ld_last;
      out_delim_q <= ld_delim;
      out_str_q   <= str_q;
      out_trunc_q <= ld_trunc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign token_char_o   = out_char_q;
  assign token_last_o   = out_last_q;
  assign is_delimiter_o = out_delim_q;
  assign in_string_o    = out_str_q;
  assign truncated_o    = out_trunc_q;

endmodule

### rtl/core/delimiter_tokenizer.sv
// delimiter tokenizer top level
// A byte that is not a delimiter is taken while idle and written to the token
// store (or dropped, for whitespace outside a string or past the capacity). A
// delimiter with characters pending is handled in steps before the next byte is
// accepted: it is taken and the first character fetched, each character is read
// out of the store's single read port, and then the delimiter token goes out;
// the readout and the delimiter token wait while the output side stalls. A
// delimiter with nothing pending goes straight to its token. End of input emits
// nothing. Results leave through an output register, so a byte may be accepted
// while the last result still waits to be taken.
module delimiter_tokenizer #(
  parameter int unsigned TokenCapacity = dtok_pkg::DefTokenCapacity
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] input_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] token_char_o,
  output logic       token_last_o,
  output logic       is_delimiter_o,
  output logic       in_string_o,
  output logic       truncated_o
);
  import dtok_pkg::*;

  localparam int unsigned AddrW = (TokenCapacity > 1) ? $clog2(TokenCapacity) : 1;
  localparam int unsigned CountW = $clog2(TokenCapacity + 1);

  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [7:0]       wr_data, rd_data;

  dtok_ctrl #(
    .TokenCapacity(TokenCapacity),
    .AddrW        (AddrW),
    .CountW       (CountW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .input_byte_i  (input_byte_i),
    .end_of_input_i(end_of_input_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_char_o  (token_char_o),
    .token_last_o  (token_last_o),
    .is_delimiter_o(is_delimiter_o),
    .in_string_o   (in_string_o),
    .truncated_o   (truncated_o),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data)
  );

  dtok_store #(
    .TokenCapacity(TokenCapacity),
    .AddrW        (AddrW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

endmodule

### rtl/core/dtok_checker.sv
// port-level checks for the delimiter tokenizer, bound to the top level
module dtok_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] token_char_o,
  input logic       token_last_o,
  input logic       is_delimiter_o,
  input logic       truncated_o
);
  import dtok_pkg::*;

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(token_char_o))
    else $error("output item changed while stalled");

  a_delim_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_delimiter_o |-> token_last_o && !truncated_o)
    else $error("delimiter token not single or marked truncated");

  // a collected token is followed at once by its delimiter
  a_delim_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && token_last_o && !is_delimiter_o
    |=> out_valid_o && is_delimiter_o)
    else $error("delimiter did not follow token");

  // no byte is taken while a token is read out
  a_no_accept_mid_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !token_last_o |-> !in_ready_o)
    else $error("input accepted in the middle of a token");

endmodule

bind delimiter_tokenizer dtok_checker u_dtok_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .token_char_o  (token_char_o),
  .token_last_o  (token_last_o),
  .is_delimiter_o(is_delimiter_o),
  .truncated_o   (truncated_o)
);
